// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL of the serial frame encoder.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, ignored while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/sfe_pkg.sv -----
// Package for the serial frame encoder: framing constants, encoder state type,
// CRC-16-CCITT byte update and base64 helpers. No dependencies.
package sfe_pkg;

  localparam logic [15:0] HDR_PKT           = 16'h0609;
  localparam logic [15:0] HDR_DATA          = 16'h0414;
  localparam logic [6:0]  FIRST_FRAME_BYTES = 7'd90;
  localparam logic [6:0]  DATA_FRAME_BYTES  = 7'd93;
  localparam logic [7:0]  NEWLINE           = 8'h0A;
  localparam logic [7:0]  PAD_CHAR          = 8'h3D;
  localparam logic [15:0] CRC_POLY          = 16'h1021;

  // Slot layout of one item's characters: three byte pushes of seven slots
  // (header pair, base64 group, newline) and a five-slot packet tail.
  localparam int TAIL_BASE  = 21;
  localparam int NSLOT      = 26;

  typedef struct packed {
    logic [15:0] gb;     // bytes waiting for a full base64 group
    logic [1:0]  gc;     // number of waiting bytes
    logic [6:0]  fbc;    // bytes in the current frame
    logic        first;  // current frame is the first of the packet
  } enc_state_t;

  typedef struct packed {
    enc_state_t  st;
    logic        hdr_v;
    logic        grp_v;
    logic [23:0] v24;
    logic        nl_v;
  } push_out_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fe;
  } slot_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] b64_char(logic [5:0] idx);
    logic [7:0] r;
    if (idx < 6'd26) begin
      r = 8'h41 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      r = 8'h61 + {2'b00, idx - 6'd26};
    end else if (idx < 6'd62) begin
      r = 8'h30 + {2'b00, idx - 6'd52};
    end else if (idx == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // Four characters of one group; positions at or past nch are padding.
  function automatic logic [3:0][7:0] group_chars(logic [23:0] v24, logic [2:0] nch);
    logic [3:0][7:0] r;
    r[0] = b64_char(v24[23:18]);
    r[1] = b64_char(v24[17:12]);
    r[2] = (nch > 3'd2) ? b64_char(v24[11:6]) : PAD_CHAR;
    r[3] = (nch > 3'd3) ? b64_char(v24[5:0])  : PAD_CHAR;
    return r;
  endfunction

  // One payload or CRC byte into the frame stream.
  function automatic push_out_t enc_push(enc_state_t s, logic [7:0] b);
    push_out_t  r;
    logic [6:0] cnt;
    logic [6:0] lim;
    r.st    = s;
    r.hdr_v = (s.fbc == 7'd0) && !s.first;
    r.grp_v = (s.gc >= 2'd2);
    r.v24   = {s.gb, b};
    if (r.grp_v) begin
      r.st.gb = 16'h0000;
      r.st.gc = 2'd0;
    end else begin
      r.st.gb = {s.gb[7:0], b};
      r.st.gc = s.gc + 2'd1;
    end
    cnt = s.fbc + 7'd1;
    lim = s.first ? FIRST_FRAME_BYTES : DATA_FRAME_BYTES;
    if (cnt >= lim) begin
      r.nl_v     = 1'b1;
      r.st.fbc   = 7'd0;
      r.st.first = 1'b0;
    end else begin
      r.nl_v   = 1'b0;
      r.st.fbc = cnt;
    end
    return r;
  endfunction

endpackage

// ----- design/smp_serial_frame_encoder.sv -----
// Serial console frame encoder: payload bytes in, framed base64 characters out.
// Depends on sfe_pkg and assert_macros.svh.
//
// Input stream: in_tdata = {packet_len, data_byte}, in_tlast marks the last
// payload byte. packet_len is only looked at on the first byte of a packet.
// Output stream: one character per transfer on out_tdata, out_tuser is set on
// the newline that closes a frame, out_tlast on the final character of a packet.
// cfg_wen/cfg_wdata load the CRC start value used from the next packet on.
//
// An item first waits in the input register; the encoder logic then lays
// all of its characters (0 to 12) into the result stage in one step, so the
// first character is offered once the item has been loaded from the input
// register into the result stage, which happens only when that stage is free.
// The result stage sends one character per cycle while the receiver is ready,
// lowest slot first. Items that produce no character pass at one per cycle while
// the result stage is empty. The input register takes the next item while the
// result stage still drains. A stalled receiver holds the current character
// and, once the input register is full, in_tready drops. Reset empties both
// stages and returns the framing state to packet start with a CRC start of zero.
`include "assert_macros.svh"

module smp_serial_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [23:8] packet_len
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic        out_tuser,  // [0] frame_end
  output logic        out_tlast,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata
);

  localparam int NSLOT = sfe_pkg::NSLOT;

  // Configuration and framing state.
  logic [15:0]        crc_start_r;
  logic [15:0]        crc_r, crc_nxt;
  sfe_pkg::enc_state_t st_r, st_nxt;
  logic               started_r, started_nxt;

  // Input register.
  logic               in_valid_r;
  logic [7:0]         in_byte_r;
  logic [15:0]        in_len_r;
  logic               in_last_r;

  // Result stage.
  sfe_pkg::slot_t [NSLOT-1:0] slots_r, slots_nxt;
  logic [NSLOT-1:0]   mask_r, mask_nxt;
  logic               blast_r;

  logic [NSLOT-1:0]   pick;
  logic [NSLOT-1:0]   rest;
  logic               stage_free;
  logic               load;

  sfe_pkg::enc_state_t st_a;
  sfe_pkg::push_out_t  pa, pb, pc;
  logic [15:0]         crc_new;
  logic [15:0]         total;
  logic                tail_grp_v;
  logic [23:0]         tail_v24;
  logic [2:0]          tail_nch;
  logic                tail_nl_v;
  logic [3:0][7:0]     gch;

  assign pick       = mask_r & (~mask_r + NSLOT'(1));
  assign rest       = mask_r & ~pick;
  assign stage_free = (rest == '0) && ((mask_r == '0) || out_tready);
  assign load       = in_valid_r && stage_free;
  assign in_tready  = !in_valid_r || stage_free;

  assign out_tvalid = (mask_r != '0);
  assign out_tlast  = blast_r && (rest == '0);

  always_comb begin
    out_tdata = 8'h00;
    out_tuser = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      out_tdata = out_tdata | (slots_r[i].ch & {8{pick[i]}});
      out_tuser = out_tuser | (slots_r[i].fe & pick[i]);
    end
  end

  // Character layout of the item held in the input register.
  always_comb begin
    slots_nxt  = '0;
    mask_nxt   = '0;
    total      = in_len_r + 16'd2;
    crc_new    = sfe_pkg::crc_byte(started_r ? crc_r : crc_start_r, in_byte_r);
    pa         = sfe_pkg::enc_push(st_r, in_byte_r);
    st_a       = '0;
    st_a.first = 1'b1;

    if (!started_r) begin
      // Packet header pair and the length group that carries the first byte.
      slots_nxt[0].ch = sfe_pkg::HDR_PKT[15:8];
      slots_nxt[1].ch = sfe_pkg::HDR_PKT[7:0];
      mask_nxt[5:0]   = 6'b111111;
      gch = sfe_pkg::group_chars({total, in_byte_r}, 3'd4);
    end else begin
      st_a = pa.st;
      slots_nxt[0].ch = sfe_pkg::HDR_DATA[15:8];
      slots_nxt[1].ch = sfe_pkg::HDR_DATA[7:0];
      mask_nxt[1:0]   = {2{pa.hdr_v}};
      mask_nxt[5:2]   = {4{pa.grp_v}};
      mask_nxt[6]     = pa.nl_v;
      gch = sfe_pkg::group_chars(pa.v24, 3'd4);
    end
    for (int j = 0; j < 4; j++) begin
      slots_nxt[2+j].ch = gch[j];
    end
    slots_nxt[6].ch = sfe_pkg::NEWLINE;
    slots_nxt[6].fe = 1'b1;

    // CRC bytes, big-endian, follow the last payload byte.
    pb = sfe_pkg::enc_push(st_a, crc_new[15:8]);
    pc = sfe_pkg::enc_push(pb.st, crc_new[7:0]);

    gch = sfe_pkg::group_chars(pb.v24, 3'd4);
    slots_nxt[7].ch  = sfe_pkg::HDR_DATA[15:8];
    slots_nxt[8].ch  = sfe_pkg::HDR_DATA[7:0];
    for (int j = 0; j < 4; j++) begin
      slots_nxt[9+j].ch = gch[j];
    end
    slots_nxt[13].ch = sfe_pkg::NEWLINE;
    slots_nxt[13].fe = 1'b1;
    mask_nxt[8:7]    = {2{in_last_r && pb.hdr_v}};
    mask_nxt[12:9]   = {4{in_last_r && pb.grp_v}};
    mask_nxt[13]     = in_last_r && pb.nl_v;

    gch = sfe_pkg::group_chars(pc.v24, 3'd4);
    slots_nxt[14].ch = sfe_pkg::HDR_DATA[15:8];
    slots_nxt[15].ch = sfe_pkg::HDR_DATA[7:0];
    for (int j = 0; j < 4; j++) begin
      slots_nxt[16+j].ch = gch[j];
    end
    slots_nxt[20].ch = sfe_pkg::NEWLINE;
    slots_nxt[20].fe = 1'b1;
    mask_nxt[15:14]  = {2{in_last_r && pc.hdr_v}};
    mask_nxt[19:16]  = {4{in_last_r && pc.grp_v}};
    mask_nxt[20]     = in_last_r && pc.nl_v;

    // Packet tail: a padded partial group and its newline, a bare newline, or nothing.
    tail_grp_v = 1'b0;
    tail_v24   = 24'h000000;
    tail_nch   = 3'd4;
    tail_nl_v  = (pc.st.fbc != 7'd0);
    case (pc.st.gc)
      2'd1: begin
        tail_grp_v = 1'b1;
        tail_v24   = {pc.st.gb[7:0], 16'h0000};
        tail_nch   = 3'd2;
        tail_nl_v  = 1'b1;
      end
      2'd2: begin
        tail_grp_v = 1'b1;
        tail_v24   = {pc.st.gb, 8'h00};
        tail_nch   = 3'd3;
        tail_nl_v  = 1'b1;
      end
      default: begin
        tail_grp_v = 1'b0;
      end
    endcase
    gch = sfe_pkg::group_chars(tail_v24, tail_nch);
    for (int j = 0; j < 4; j++) begin
      slots_nxt[sfe_pkg::TAIL_BASE+j].ch = gch[j];
    end
    slots_nxt[sfe_pkg::TAIL_BASE+4].ch = sfe_pkg::NEWLINE;
    slots_nxt[sfe_pkg::TAIL_BASE+4].fe = 1'b1;
    mask_nxt[sfe_pkg::TAIL_BASE+3:sfe_pkg::TAIL_BASE] = {4{in_last_r && tail_grp_v}};
    mask_nxt[sfe_pkg::TAIL_BASE+4] = in_last_r && tail_nl_v;

    // A packet end returns everything to packet start.
    if (in_last_r) begin
      st_nxt       = '0;
      st_nxt.first = 1'b1;
      crc_nxt      = crc_start_r;
      started_nxt  = 1'b0;
    end else begin
      st_nxt      = st_a;
      crc_nxt     = crc_new;
      started_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_start_r <= 16'h0000;
    end else if (cfg_wen) begin
      crc_start_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata[7:0];
      in_len_r  <= in_tdata[23:8];
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r        <= 16'h0000;
      st_r         <= '{gb: 16'h0000, gc: 2'd0, fbc: 7'd0, first: 1'b1};
      started_r    <= 1'b0;
      mask_r       <= '0;
      blast_r      <= 1'b0;
    end else if (load) begin
      crc_r     <= crc_nxt;
      st_r      <= st_nxt;
      started_r <= started_nxt;
      mask_r    <= mask_nxt;
      blast_r   <= in_last_r;
    end else if (out_tvalid && out_tready) begin
      mask_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots_r <= slots_nxt;
    end
  end

  `ASSERT_CLK(a_tlast_closed, (out_tvalid && out_tlast) |-> !started_r, "tlast in open packet")
  `ASSERT_CLK(a_fe_newline, (out_tvalid && out_tuser) |-> (out_tdata == sfe_pkg::NEWLINE), "fe")
  `ASSERT_CLK(a_first_fill, st_r.first |-> (st_r.fbc < sfe_pkg::FIRST_FRAME_BYTES), "overfull")
  `ASSERT_CLK(a_data_fill, st_r.fbc < sfe_pkg::DATA_FRAME_BYTES, "data frame overfull")

endmodule

// ----- verif/smp_serial_frame_encoder_tb.sv -----
// Self-checking testbench for smp_serial_frame_encoder: payload packets go in,
// framed base64 characters come out and are compared with an in-bench predictor.
// Depends on sfe_pkg for the framing constants and on the encoder RTL.
`timescale 1ns / 100ps

module smp_serial_frame_encoder_tb;

  localparam int CYCLE_LIMIT     = 1_200_000;
  localparam int RANDOM_ITEMS    = 50;
  localparam int MAX_REPORTS     = 10;
  localparam int CHARS_PER_ITEM  = 16;
  localparam int SETTLE_CYCLES   = 6;
  localparam int TAIL_CYCLES     = 20;

  typedef struct {
    logic [7:0] ch;
    logic       fe;
    logic       lst;
  } char_exp_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // [7:0] data_byte, [23:8] packet_len
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;   // [7:0] out_char
  logic        out_tuser;   // [0] frame_end
  logic        out_tlast;
  logic        cfg_wen;
  logic [15:0] cfg_wdata;

  // Predictor state of the encoder.
  logic [15:0] crc_seed  = 16'h0000;
  logic [15:0] crc_acc   = 16'h0000;
  logic [15:0] grp_bytes = 16'h0000;
  logic [1:0]  grp_cnt   = 2'd0;
  logic [6:0]  frm_cnt   = 7'd0;
  logic        in_first  = 1'b1;
  logic        pkt_open  = 1'b0;
  int          item_chars;

  char_exp_t   exp_chars[$];
  char_exp_t   want;
  int          err_count = 0;
  int          cycle_cnt = 0;
  int          stall_left = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;

  smp_serial_frame_encoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] crc_ccitt_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {b, 8'h00};
    repeat (8) r = r[15] ? ((r << 1) ^ sfe_pkg::CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic logic [7:0] b64_sym(logic [5:0] idx);
    logic [7:0] r;
    if (idx < 6'd26) begin
      r = 8'd65 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      r = 8'd97 + {2'b00, idx - 6'd26};
    end else if (idx < 6'd62) begin
      r = 8'd48 + {2'b00, idx - 6'd52};
    end else if (idx == 6'd62) begin
      r = 8'd43;
    end else begin
      r = 8'd47;
    end
    return r;
  endfunction

  function automatic void add_char(logic [7:0] ch, logic fe);
    char_exp_t e;
    if (item_chars >= CHARS_PER_ITEM) return;
    e.ch  = ch;
    e.fe  = fe;
    e.lst = 1'b0;
    exp_chars.push_back(e);
    item_chars++;
  endfunction

  function automatic void add_quad(logic [23:0] v, int nsym);
    for (int i = 0; i < 4; i++) begin
      add_char((i < nsym) ? b64_sym(v[23 - 6 * i -: 6]) : sfe_pkg::PAD_CHAR, 1'b0);
    end
  endfunction

  // One payload or CRC byte after the header group of the packet.
  function automatic void frame_push(logic [7:0] b);
    logic [6:0] cap;
    cap = in_first ? sfe_pkg::FIRST_FRAME_BYTES : sfe_pkg::DATA_FRAME_BYTES;
    if (frm_cnt == 0 && !in_first) begin
      add_char(sfe_pkg::HDR_DATA[15:8], 1'b0);
      add_char(sfe_pkg::HDR_DATA[7:0], 1'b0);
    end
    if (grp_cnt >= 2) begin
      add_quad({grp_bytes, b}, 4);
      grp_bytes = 16'h0000;
      grp_cnt   = 2'd0;
    end else begin
      grp_bytes = {grp_bytes[7:0], b};
      grp_cnt   = grp_cnt + 2'd1;
    end
    frm_cnt = frm_cnt + 7'd1;
    if (frm_cnt >= cap) begin
      add_char(sfe_pkg::NEWLINE, 1'b1);
      frm_cnt  = 7'd0;
      in_first = 1'b0;
    end
  endfunction

  function automatic void predict_item(logic [7:0] b, logic [15:0] plen, logic lst);
    logic [15:0] total;
    item_chars = 0;
    if (!pkt_open) begin
      // The length field wraps at 16 bits and is never checked against the data.
      total   = plen + 16'd2;
      crc_acc = crc_ccitt_step(crc_seed, b);
      add_char(sfe_pkg::HDR_PKT[15:8], 1'b0);
      add_char(sfe_pkg::HDR_PKT[7:0], 1'b0);
      add_quad({total, b}, 4);
      pkt_open  = 1'b1;
      in_first  = 1'b1;
      frm_cnt   = 7'd0;
      grp_bytes = 16'h0000;
      grp_cnt   = 2'd0;
    end else begin
      crc_acc = crc_ccitt_step(crc_acc, b);
      frame_push(b);
    end
    if (lst) begin
      frame_push(crc_acc[15:8]);
      frame_push(crc_acc[7:0]);
      if (grp_cnt == 1) begin
        add_quad({grp_bytes[7:0], 16'h0000}, 2);
        add_char(sfe_pkg::NEWLINE, 1'b1);
      end else if (grp_cnt == 2) begin
        add_quad({grp_bytes, 8'h00}, 3);
        add_char(sfe_pkg::NEWLINE, 1'b1);
      end else if (frm_cnt != 0) begin
        add_char(sfe_pkg::NEWLINE, 1'b1);
      end
      if (item_chars > 0) exp_chars[exp_chars.size() - 1].lst = 1'b1;
      crc_acc   = crc_seed;
      grp_bytes = 16'h0000;
      grp_cnt   = 2'd0;
      frm_cnt   = 7'd0;
      in_first  = 1'b1;
      pkt_open  = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 3);
  endfunction

  task automatic send_payload_byte(input logic [7:0] b, input logic [15:0] plen,
                                   input logic lst);
    int gap;
    gap = (tx_idle_en && $urandom_range(0, 1) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {plen, b};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(b, plen, lst);
  endtask

  // A negative fill value gives random payload bytes. Bytes after the first
  // carry a random length field, which the block has to ignore.
  task automatic send_packet(input int n, input logic [15:0] plen, input int fill);
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
      send_payload_byte(b, (k == 0) ? plen : 16'($urandom_range(0, 65535)), k == n - 1);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (exp_chars.size() != 0) @(posedge clk);
    // Items that produce no character may still sit in the pipeline.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_crc_start(input logic [15:0] value);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    crc_seed = value;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_short_packets();
    send_packet(1, 16'd1, 8'h00);
    send_packet(1, 16'd65533, 8'hFF);
    send_packet(1, 16'd0, -1);
    send_packet(1, 16'd65534, -1);
    send_packet(1, 16'd65535, -1);
    send_payload_byte(8'h00, 16'd2, 1'b0);
    send_payload_byte(8'hFF, 16'hFFFF, 1'b1);
    send_packet(3, 16'd3, -1);
    send_packet(4, 16'd100, 8'hA5);
    send_packet(5, 16'd5, 8'hFF);
  endtask

  task automatic test_crc_start();
    write_crc_start(16'hFFFF);
    send_packet(3, 16'd3, -1);
    write_crc_start(16'h1D0F);
    send_packet(2, 16'd2, -1);
    // A new start value written inside a packet only applies from the next one.
    send_payload_byte(8'h31, 16'd4, 1'b0);
    send_payload_byte(8'h32, 16'h0000, 1'b0);
    send_payload_byte(8'h33, 16'h0000, 1'b0);
    write_crc_start(16'h8000);
    send_payload_byte(8'h34, 16'h0000, 1'b1);
    send_packet(2, 16'd2, -1);
    write_crc_start(16'h0000);
    send_packet(1, 16'd1, -1);
  endtask

  task automatic test_frame_boundaries();
    write_crc_start(16'($urandom_range(0, 65535)));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_packet(90, 16'd90, -1);   // one CRC byte spills into a data frame
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_packet(182, 16'd182, -1); // first and second frame both full
  endtask

  task automatic test_random_packets();
    int items_sent;
    int n;
    int r;
    logic [15:0] plen;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(1, 6);
      end else begin
        n = $urandom_range(7, 20);
      end
      plen = ($urandom_range(0, 9) < 7) ? 16'(n) : 16'($urandom_range(0, 65535));
      tx_idle_en = ($urandom_range(0, 4) != 0);
      rx_idle_en = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) begin
        write_crc_start(16'($urandom_range(0, 65535)));
      end else if ($urandom_range(0, 7) == 0) begin
        wait_drained();
      end
      send_packet(n, plen, -1);
      items_sent += n;
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= idle_len() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_chars.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("cycle %0d: unexpected char %h frame_end %b last %b", cycle_cnt,
                   out_tdata, out_tuser, out_tlast);
        end
      end else begin
        want = exp_chars.pop_front();
        if (out_tdata !== want.ch || out_tuser !== want.fe || out_tlast !== want.lst) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("cycle %0d: expected char %h frame_end %b last %b, got %h %b %b",
                     cycle_cnt, want.ch, want.fe, want.lst, out_tdata, out_tuser, out_tlast);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 24'h000000;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_wen    = 1'b0;
    cfg_wdata  = 16'h0000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_short_packets();
    test_crc_start();
    test_frame_boundaries();
    test_random_packets();

    in_tvalid <= 1'b0;
    while (exp_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0 && exp_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
